// ===== design/vrt_pkg.sv =====
package vrt_pkg;

  localparam int DEF_GRID      = 64;
  localparam int DEF_MAX_STEPS = 4096;

  localparam logic [15:0] MAXD_RESET = 16'd2048;

  // signed cell coordinate, wide enough for the start cell plus the longest walk
  localparam int CELL_W = 12;
  // stepped distance, 2^-16 voxel units
  localparam int T_W    = 33;
  // distance with a "never" flag on top
  localparam int TM_W   = T_W + 1;
  localparam int DIV_NW = 31;
  localparam int DIV_DW = 16;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       clear;
    logic       map_wr;
    logic       load;
    logic       div_start;
    logic       div_store;
    logic [1:0] axis;
    logic       step;
    logic       res_load;
    logic       res_hit;
  } vrt_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic div_done;
    logic can_step;
    logic hit_now;
  } vrt_sts_t;

endpackage

// ===== design/vrt_div.sv =====
module vrt_div import vrt_pkg::*; #(
  parameter int NW = DIV_NW,
  parameter int DW = DIV_DW
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_a_i,
  input  logic [NW-1:0] num_b_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_a_o,
  output logic [NW-1:0] quo_b_o
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] qa_q, qb_q;
  logic [DW-1:0] ra_q, rb_q, den_q;
  logic [DW:0]   sa, sb;
  logic          ga, gb;
  logic [DW-1:0] na, nb;

  // restoring division, one quotient bit per cycle for both numerators
  always_comb begin
    sa = {ra_q, qa_q[NW-1]};
    sb = {rb_q, qb_q[NW-1]};
    ga = sa >= {1'b0, den_q};
    gb = sb >= {1'b0, den_q};
    na = ga ? DW'(sa - {1'b0, den_q}) : DW'(sa);
    nb = gb ? DW'(sb - {1'b0, den_q}) : DW'(sb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qa_q  <= num_a_i;
      qb_q  <= num_b_i;
      ra_q  <= '0;
      rb_q  <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      qa_q <= {qa_q[NW-2:0], ga};
      qb_q <= {qb_q[NW-2:0], gb};
      ra_q <= na;
      rb_q <= nb;
    end
  end

  assign done_o  = done_q;
  assign quo_a_o = qa_q;
  assign quo_b_o = qb_q;

endmodule

// ===== design/vrt_datapath.sv =====
module vrt_datapath import vrt_pkg::*; #(
  parameter int GRID_X    = DEF_GRID,
  parameter int GRID_Y    = DEF_GRID,
  parameter int GRID_Z    = DEF_GRID,
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic [5:0]         cell_x_i,
  input  logic [5:0]         cell_y_i,
  input  logic [5:0]         cell_z_i,
  input  logic               cell_hittable_i,
  input  logic signed [15:0] origin_x_i,
  input  logic signed [15:0] origin_y_i,
  input  logic signed [15:0] origin_z_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  vrt_cmd_t           cmd_i,
  output vrt_sts_t           sts_o,
  output logic               hit_o,
  output logic [5:0]         hit_x_o,
  output logic [5:0]         hit_y_o,
  output logic [5:0]         hit_z_o,
  output logic signed [1:0]  normal_x_o,
  output logic signed [1:0]  normal_y_o,
  output logic signed [1:0]  normal_z_o
);

  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int ZW    = $clog2(GRID_Z);
  localparam int DEPTH = GRID_Y * GRID_Z;
  localparam int RW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_STEPS + 1);

  localparam logic [TM_W-1:0] T_NEVER = {1'b1, {T_W{1'b0}}};

  logic [15:0] maxd_q;

  // map stored as rows of GRID_X bits, row index y*GRID_Z + z
  logic [GRID_X-1:0] hit_map [DEPTH];
  logic [GRID_X-1:0] rd_q;
  logic [RW-1:0]     clr_q;

  logic signed [15:0] o_in [3];
  logic signed [15:0] d_in [3];
  logic [15:0]        mag_in [3];
  logic [16:0]        nud_in [3];
  logic signed [31:0] p_in [3];

  logic signed [31:0]       p_q [3];
  logic [15:0]              mag_q [3];
  logic [2:0]               neg_q, zero_q;
  logic signed [CELL_W-1:0] cell_q [3];
  logic signed [CELL_W-1:0] cell_nx [3];
  logic [TM_W-1:0]          tmax_q [3];
  logic [DIV_NW-1:0]        tdelta_q [3];
  logic [T_W-1:0]           t_q;
  logic [SW-1:0]            steps_q;
  logic [1:0]               last_q;

  logic [1:0]        sel;
  logic [21:0]       frac;
  logic [22:0]       bdist;
  logic              div_done;
  logic [DIV_NW-1:0] quo_a, quo_b;
  logic [23:0]       limit;
  logic              in_grid;
  logic [XW-1:0]     rd_x;
  logic [RW-1:0]     rd_row, wr_row;
  logic [31:0]       wx32;
  logic              wr_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxd_q <= MAXD_RESET;
    end else if (cfg_we_i) begin
      maxd_q <= cfg_wdata_i;
    end
  end

  assign o_in[0] = origin_x_i;
  assign o_in[1] = origin_y_i;
  assign o_in[2] = origin_z_i;
  assign d_in[0] = dir_x_i;
  assign d_in[1] = dir_y_i;
  assign d_in[2] = dir_z_i;

  // nudged origin in 2^-22 voxel units
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mag_in[a] = d_in[a][15] ? 16'(-d_in[a]) : d_in[a];
      nud_in[a] = 17'((32'(mag_in[a]) * 32'd2621) >> 10);
      if (d_in[a][15]) begin
        p_in[a] = (32'(o_in[a]) <<< 14) - $signed({15'b0, nud_in[a]});
      end else begin
        p_in[a] = (32'(o_in[a]) <<< 14) + $signed({15'b0, nud_in[a]});
      end
    end
  end

  // distance to the first boundary along the axis in setup
  always_comb begin
    frac  = p_q[cmd_i.axis][21:0];
    bdist = neg_q[cmd_i.axis] ? {1'b0, frac} : 23'(24'h400000 - {2'b0, frac});
  end

  vrt_div #(
    .NW(DIV_NW),
    .DW(DIV_DW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_a_i({bdist, 8'b0}),
    .num_b_i(DIV_NW'(32'h4000_0000)),
    .den_i  (mag_q[cmd_i.axis]),
    .done_o (div_done),
    .quo_a_o(quo_a),
    .quo_b_o(quo_b)
  );

  // x only when strictly smallest, y wins ties with x, z takes the rest
  always_comb begin
    if (tmax_q[0] < tmax_q[1]) begin
      sel = (tmax_q[0] < tmax_q[2]) ? AXIS_X : AXIS_Z;
    end else begin
      sel = (tmax_q[1] < tmax_q[2]) ? AXIS_Y : AXIS_Z;
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cell_nx[a] = cell_q[a];
    end
    cell_nx[sel] = neg_q[sel] ? cell_q[sel] - 1'b1 : cell_q[sel] + 1'b1;
  end

  assign limit  = {maxd_q, 8'b0};
  assign rd_row = RW'(32'(cell_nx[1][YW-1:0]) * GRID_Z + 32'(cell_nx[2][ZW-1:0]));
  assign rd_x   = cell_q[0][XW-1:0];
  assign wr_row = RW'(32'(cell_y_i) * GRID_Z + 32'(cell_z_i));
  assign wx32   = 32'(cell_x_i);
  assign wr_ok  = (32'(cell_x_i) < GRID_X) && (32'(cell_y_i) < GRID_Y)
                  && (32'(cell_z_i) < GRID_Z);

  assign in_grid = !cell_q[0][CELL_W-1] && (cell_q[0] < CELL_W'(GRID_X))
                && !cell_q[1][CELL_W-1] && (cell_q[1] < CELL_W'(GRID_Y))
                && !cell_q[2][CELL_W-1] && (cell_q[2] < CELL_W'(GRID_Z));

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      hit_map[clr_q] <= '0;
    end else if (cmd_i.map_wr && wr_ok) begin
      hit_map[wr_row][wx32[XW-1:0]] <= cell_hittable_i;
    end
    if (cmd_i.step) begin
      rd_q <= hit_map[rd_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int a = 0; a < 3; a++) begin
        p_q[a]    <= p_in[a];
        mag_q[a]  <= mag_in[a];
        neg_q[a]  <= d_in[a][15];
        zero_q[a] <= (d_in[a] == 16'sd0);
        cell_q[a] <= CELL_W'(p_in[a] >>> 22);
      end
      t_q     <= '0;
      steps_q <= '0;
    end
    if (cmd_i.div_store) begin
      tmax_q[cmd_i.axis]   <= zero_q[cmd_i.axis] ? T_NEVER : TM_W'(quo_a);
      tdelta_q[cmd_i.axis] <= zero_q[cmd_i.axis] ? '0 : quo_b;
    end
    if (cmd_i.step) begin
      for (int a = 0; a < 3; a++) begin
        cell_q[a] <= cell_nx[a];
      end
      t_q         <= tmax_q[sel][T_W-1:0];
      tmax_q[sel] <= tmax_q[sel] + TM_W'(tdelta_q[sel]);
      steps_q     <= steps_q + 1'b1;
      last_q      <= sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      hit_o      <= cmd_i.res_hit;
      hit_x_o    <= cmd_i.res_hit ? cell_q[0][5:0] : 6'd0;
      hit_y_o    <= cmd_i.res_hit ? cell_q[1][5:0] : 6'd0;
      hit_z_o    <= cmd_i.res_hit ? cell_q[2][5:0] : 6'd0;
      normal_x_o <= (cmd_i.res_hit && last_q == AXIS_X) ? (neg_q[0] ? 2'sd1 : -2'sd1) : 2'sd0;
      normal_y_o <= (cmd_i.res_hit && last_q == AXIS_Y) ? (neg_q[1] ? 2'sd1 : -2'sd1) : 2'sd0;
      normal_z_o <= (cmd_i.res_hit && last_q == AXIS_Z) ? (neg_q[2] ? 2'sd1 : -2'sd1) : 2'sd0;
    end
  end

  assign sts_o.clear_last = (clr_q == RW'(DEPTH - 1));
  assign sts_o.div_done   = div_done;
  assign sts_o.can_step   = (32'(steps_q) < MAX_STEPS) && (t_q <= T_W'(limit))
                            && !tmax_q[sel][TM_W-1];
  assign sts_o.hit_now    = in_grid && rd_q[rd_x];

endmodule

// ===== design/vrt_ctrl.sv =====
module vrt_ctrl import vrt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  input  logic     s_kind_i,
  output logic     s_ready_o,
  input  logic     m_ready_i,
  output logic     m_valid_o,
  input  vrt_sts_t sts_i,
  output vrt_cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIVS  = 3'd2;
  localparam logic [2:0] S_DIVW  = 3'd3;
  localparam logic [2:0] S_STEP  = 3'd4;
  localparam logic [2:0] S_TEST  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic       hit_q, hit_d;
  logic       mvalid_q, mvalid_d;

  always_comb begin
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    state_d     = state_q;
    axis_d      = axis_q;
    hit_d       = hit_q;
    mvalid_d    = mvalid_q && !m_ready_i;
    s_ready_o   = (state_q == S_IDLE);
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_valid_i) begin
          if (s_kind_i == KIND_CAST) begin
            cmd_o.load = 1'b1;
            axis_d     = AXIS_X;
            state_d    = S_DIVS;
          end else begin
            cmd_o.map_wr = 1'b1;
          end
        end
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          cmd_o.div_store = 1'b1;
          if (axis_q == AXIS_Z) begin
            state_d = S_STEP;
          end else begin
            axis_d  = axis_q + 1'b1;
            state_d = S_DIVS;
          end
        end
      end
      S_STEP: begin
        if (sts_i.can_step) begin
          cmd_o.step = 1'b1;
          state_d    = S_TEST;
        end else begin
          hit_d   = 1'b0;
          state_d = S_FIN;
        end
      end
      S_TEST: begin
        if (sts_i.hit_now) begin
          hit_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_STEP;
        end
      end
      S_FIN: begin
        // result register free or emptying this cycle
        if (!mvalid_q || m_ready_i) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_hit  = hit_q;
          mvalid_d       = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      axis_q   <= AXIS_X;
      hit_q    <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      axis_q   <= axis_d;
      hit_q    <= hit_d;
      mvalid_q <= mvalid_d;
    end
  end

  assign m_valid_o = mvalid_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_ready_o)
    else $error("input taken during map clear");

  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!mvalid_q || m_ready_i))
    else $error("result overwrites a pending transfer");

  a_step_then_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |=> (state_q == S_TEST))
    else $error("map read not tested");

  a_store_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_store |-> ($past(state_q) == S_DIVS || $past(state_q) == S_DIVW))
    else $error("divider result stored without a division");

endmodule

// ===== design/voxel_ray_traversal.sv =====
// Voxel ray caster over a one-bit hittable map. A write transfer (tuser 0) sets one map
// cell. A cast transfer (tuser 1) gives one result: the first hittable in-grid cell
// entered with its face normal, or a miss with all fields zero. Setup of a cast runs the
// shared bit-serial divider that forms the first crossing and per-cell distance of each
// axis (31 quotient bits each); each cell walked then takes a step with its registered
// map row read and a test of that row, and the result is loaded last. After reset the map
// is cleared one row a cycle, GRID_Y*GRID_Z rows (4096 by default), before the first
// transfer is taken; max_distance may be written during that.
module voxel_ray_traversal import vrt_pkg::*; #(
  parameter int GRID_X    = DEF_GRID,
  parameter int GRID_Y    = DEF_GRID,
  parameter int GRID_Z    = DEF_GRID,
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_x, cell_y, cell_z, cell_hittable, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [119:0] s_axis_tdata,
  // kind
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit_x, hit_y, hit_z, normal_x, normal_y, normal_z
  output logic [23:0]  m_axis_tdata,
  // hit
  output logic         m_axis_tuser
);

  vrt_cmd_t          cmd;
  vrt_sts_t          sts;
  logic [5:0]        hx, hy, hz;
  logic signed [1:0] nx, ny, nz;

  vrt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_kind_i (s_axis_tuser),
    .s_ready_o(s_axis_tready),
    .m_ready_i(m_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  vrt_datapath #(
    .GRID_X   (GRID_X),
    .GRID_Y   (GRID_Y),
    .GRID_Z   (GRID_Z),
    .MAX_STEPS(MAX_STEPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cell_x_i       (s_axis_tdata[5:0]),
    .cell_y_i       (s_axis_tdata[11:6]),
    .cell_z_i       (s_axis_tdata[17:12]),
    .cell_hittable_i(s_axis_tdata[18]),
    .origin_x_i     ($signed(s_axis_tdata[34:19])),
    .origin_y_i     ($signed(s_axis_tdata[50:35])),
    .origin_z_i     ($signed(s_axis_tdata[66:51])),
    .dir_x_i        ($signed(s_axis_tdata[82:67])),
    .dir_y_i        ($signed(s_axis_tdata[98:83])),
    .dir_z_i        ($signed(s_axis_tdata[114:99])),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .hit_o          (m_axis_tuser),
    .hit_x_o        (hx),
    .hit_y_o        (hy),
    .hit_z_o        (hz),
    .normal_x_o     (nx),
    .normal_y_o     (ny),
    .normal_z_o     (nz)
  );

  assign m_axis_tdata = {nz, ny, nx, hz, hy, hx};

endmodule
